// ===== rtl/slcan_ascii_frame_parser_defines.svh =====
// -----------------------------------------------------------------------------
// Serial-CAN frame parser assertion macros
// Shared assertion forms for the serial-CAN frame parser checkers.
// -----------------------------------------------------------------------------
`ifndef SLCAN_ASCII_FRAME_PARSER_DEFINES_SVH
`define SLCAN_ASCII_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLCAN_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("serial-CAN parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLCAN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("serial-CAN parser check failed");

`endif

// ===== rtl/slcan_pkg.sv =====
// -----------------------------------------------------------------------------
// Serial-CAN parser package
// Character codes, defaults and the token type passed from front to back.
// -----------------------------------------------------------------------------
package slcan_pkg;

  localparam int DEFAULT_MAX_DATA_BYTES = 8;
  localparam int DATA_PORTS             = 8;
  localparam int QUEUE_DEPTH            = 2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BELL  = 8'h07;
  localparam logic [7:0] CH_FRAME = 8'h74;
  localparam logic [7:0] CH_ACK   = 8'h7A;

  typedef enum logic [2:0] {
    TOK_CR,
    TOK_BELL,
    TOK_FRAME,
    TOK_ACK,
    TOK_HEX,
    TOK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] nibble;
  } tok_t;

endpackage

// ===== rtl/slcan_queue.sv =====
// -----------------------------------------------------------------------------
// Serial-CAN token queue
// Small register queue that decouples the character front from the parser.
// -----------------------------------------------------------------------------
module slcan_queue
  import slcan_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/slcan_front.sv =====
// -----------------------------------------------------------------------------
// Serial-CAN character front
// Accepts received characters and classifies each into a parser token.
// -----------------------------------------------------------------------------
module slcan_front
  import slcan_pkg::*;
(
  input  logic       rx_valid,
  input  logic [7:0] rx_char,
  output logic       rx_stall,
  input  logic       queue_full,
  output logic       push,
  output tok_t       tok
);

  assign rx_stall = queue_full;
  assign push     = rx_valid && !queue_full;

  always_comb begin
    tok.nibble = 4'd0;
    if (rx_char == CH_CR) begin
      tok.kind = TOK_CR;
    end else if (rx_char == CH_BELL) begin
      tok.kind = TOK_BELL;
    end else if (rx_char == CH_FRAME) begin
      tok.kind = TOK_FRAME;
    end else if (rx_char == CH_ACK) begin
      tok.kind = TOK_ACK;
    end else if (rx_char >= 8'h30 && rx_char <= 8'h39) begin
      tok.kind   = TOK_HEX;
      tok.nibble = rx_char[3:0];
    end else if ((rx_char >= 8'h41 && rx_char <= 8'h46) ||
                 (rx_char >= 8'h61 && rx_char <= 8'h66)) begin
      tok.kind   = TOK_HEX;
      tok.nibble = 4'(rx_char[2:0] + 3'd1) + 4'd8;
    end else begin
      tok.kind = TOK_OTHER;
    end
  end

endmodule

// ===== rtl/slcan_back.sv =====
// -----------------------------------------------------------------------------
// Serial-CAN line parser
// Carries out one token per cycle on the line state, while a held result is not stalled, and holds the result.
// -----------------------------------------------------------------------------
module slcan_back
  import slcan_pkg::*;
#(
  parameter int MAX_DATA_BYTES = DEFAULT_MAX_DATA_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tok_ready,
  input  tok_t        tok,
  output logic        pop,
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic        status,
  output logic [11:0] frame_id,
  output logic [3:0]  frame_length,
  output logic [7:0]  res_data [DATA_PORTS]
);

  localparam int         ACC_W   = 8 * MAX_DATA_BYTES;
  localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FRAME,
    KIND_ACK,
    KIND_OTHER
  } line_kind_t;

  logic [4:0]       char_position, char_position_next;
  line_kind_t       line_kind, line_kind_next;
  logic             error_seen, error_seen_next;
  logic [11:0]      id_acc, id_acc_next;
  logic [3:0]       length_value, length_value_next;
  logic [ACC_W-1:0] data_acc, data_acc_next;
  logic             emit;
  logic             emit_error;
  logic [5:0]       data_end;
  logic [4:0]       offset;
  logic             is_hex;

  assign pop      = tok_ready && (!frame_valid || !frame_stall);
  assign data_end = 6'd5 + {1'b0, length_value, 1'b0};
  assign offset   = char_position - 5'd5;
  assign is_hex   = (tok.kind == TOK_HEX);

  always_comb begin
    char_position_next = char_position;
    line_kind_next     = line_kind;
    error_seen_next    = error_seen;
    id_acc_next        = id_acc;
    length_value_next  = length_value;
    data_acc_next      = data_acc;
    emit               = 1'b0;
    emit_error         = 1'b0;
    unique case (tok.kind)
      TOK_BELL, TOK_CR: begin
        if (tok.kind == TOK_BELL) begin
          emit       = 1'b1;
          emit_error = 1'b1;
        end else if (char_position == 5'd0 || line_kind == KIND_OTHER) begin
          emit       = 1'b1;
          emit_error = 1'b1;
        end else if (line_kind == KIND_ACK) begin
          emit = 1'b0;
        end else begin
          emit       = 1'b1;
          emit_error = (char_position < 5'd5) || error_seen ||
                       ({1'b0, char_position} < data_end);
        end
        char_position_next = '0;
        line_kind_next     = KIND_NONE;
        error_seen_next    = 1'b0;
        id_acc_next        = '0;
        length_value_next  = '0;
        data_acc_next      = '0;
      end
      TOK_FRAME, TOK_ACK, TOK_HEX, TOK_OTHER: begin
        if (char_position == 5'd0) begin
          if (tok.kind == TOK_FRAME) begin
            line_kind_next = KIND_FRAME;
          end else if (tok.kind == TOK_ACK) begin
            line_kind_next = KIND_ACK;
          end else begin
            line_kind_next = KIND_OTHER;
          end
        end else if (line_kind == KIND_FRAME && !error_seen) begin
          if (char_position <= 5'd3) begin
            if (!is_hex) begin
              error_seen_next = 1'b1;
            end else begin
              id_acc_next = {id_acc[7:0], tok.nibble};
            end
          end else if (char_position == 5'd4) begin
            if (!is_hex || tok.nibble > MAX_LEN) begin
              error_seen_next = 1'b1;
            end else begin
              length_value_next = tok.nibble;
            end
          end else if ({1'b0, char_position} < data_end) begin
            if (!is_hex) begin
              error_seen_next = 1'b1;
            end else begin
              for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                if (offset[4:1] == 4'(i)) begin
                  if (offset[0]) begin
                    data_acc_next[8*i +: 4] = data_acc[8*i +: 4] | tok.nibble;
                  end else begin
                    data_acc_next[8*i+4 +: 4] = data_acc[8*i+4 +: 4] | tok.nibble;
                  end
                end
              end
            end
          end
        end
        if (char_position != 5'd31) begin
          char_position_next = char_position + 5'd1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      line_kind     <= KIND_NONE;
      error_seen    <= 1'b0;
      id_acc        <= '0;
      length_value  <= '0;
      data_acc      <= '0;
      frame_valid   <= 1'b0;
    end else begin
      if (pop) begin
        char_position <= char_position_next;
        line_kind     <= line_kind_next;
        error_seen    <= error_seen_next;
        id_acc        <= id_acc_next;
        length_value  <= length_value_next;
        data_acc      <= data_acc_next;
      end
      if (pop && emit) begin
        frame_valid <= 1'b1;
      end else if (!frame_stall) begin
        frame_valid <= 1'b0;
      end
    end
    if (pop && emit) begin
      status       <= emit_error;
      frame_id     <= emit_error ? 12'd0 : id_acc;
      frame_length <= emit_error ? 4'd0 : length_value;
      for (int i = 0; i < DATA_PORTS; i++) begin
        if (i < MAX_DATA_BYTES && !emit_error) begin
          res_data[i] <= data_acc[8*i +: 8];
        end else begin
          res_data[i] <= 8'd0;
        end
      end
    end
  end

endmodule

// ===== rtl/slcan_ascii_frame_parser.sv =====
// -----------------------------------------------------------------------------
// Serial-CAN ASCII frame parser
// Parses 't' III L DD..DD CR receive lines into CAN frame results.
// -----------------------------------------------------------------------------
// One character is accepted per cycle and the parser keeps that pace without
// gaps while the result side is not stalled. A character passes the classifying
// front, waits in a two-entry token queue and is applied by the line parser,
// which handles one token per cycle. A result is registered on the frame port
// when the parser applies the bell or carriage return that ends a line, but
// a carriage return ending a 'z' line gives none. The output register holds a
// result under stall while the queue keeps taking characters until it fills.
module slcan_ascii_frame_parser
  import slcan_pkg::*;
#(
  parameter int MAX_DATA_BYTES = DEFAULT_MAX_DATA_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_char,
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic        status,
  output logic [11:0] frame_id,
  output logic [3:0]  frame_length,
  output logic [7:0]  data_byte_0,
  output logic [7:0]  data_byte_1,
  output logic [7:0]  data_byte_2,
  output logic [7:0]  data_byte_3,
  output logic [7:0]  data_byte_4,
  output logic [7:0]  data_byte_5,
  output logic [7:0]  data_byte_6,
  output logic [7:0]  data_byte_7
);

  tok_t       front_tok;
  tok_t       back_tok;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_empty;
  logic [7:0] res_data [DATA_PORTS];

  slcan_front u_front (
    .rx_valid   (rx_valid),
    .rx_char    (rx_char),
    .rx_stall   (rx_stall),
    .queue_full (queue_full),
    .push       (push),
    .tok        (front_tok)
  );

  slcan_queue #(
    .WIDTH ($bits(tok_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_tok),
    .full    (queue_full),
    .rd_en   (pop),
    .rd_data (back_tok),
    .empty   (queue_empty)
  );

  slcan_back #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .tok_ready    (!queue_empty),
    .tok          (back_tok),
    .pop          (pop),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .status       (status),
    .frame_id     (frame_id),
    .frame_length (frame_length),
    .res_data     (res_data)
  );

  assign data_byte_0 = res_data[0];
  assign data_byte_1 = res_data[1];
  assign data_byte_2 = res_data[2];
  assign data_byte_3 = res_data[3];
  assign data_byte_4 = res_data[4];
  assign data_byte_5 = res_data[5];
  assign data_byte_6 = res_data[6];
  assign data_byte_7 = res_data[7];

endmodule

// ===== rtl/slcan_checker.sv =====
// -----------------------------------------------------------------------------
// Serial-CAN parser checker
// Port-level checks on the frame results of the serial-CAN parser.
// -----------------------------------------------------------------------------
`include "slcan_ascii_frame_parser_defines.svh"

module slcan_checker
  import slcan_pkg::*;
#(
  parameter int MAX_DATA_BYTES = DEFAULT_MAX_DATA_BYTES
) (
  input logic        clk,
  input logic        rst,
  input logic        frame_valid,
  input logic        frame_stall,
  input logic        status,
  input logic [11:0] frame_id,
  input logic [3:0]  frame_length,
  input logic [7:0]  data_byte_0,
  input logic [7:0]  data_byte_1,
  input logic [7:0]  data_byte_2,
  input logic [7:0]  data_byte_3,
  input logic [7:0]  data_byte_4,
  input logic [7:0]  data_byte_5,
  input logic [7:0]  data_byte_6,
  input logic [7:0]  data_byte_7
);

  localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

  logic [63:0] all_bytes;

  assign all_bytes = {data_byte_7, data_byte_6, data_byte_5, data_byte_4,
                      data_byte_3, data_byte_2, data_byte_1, data_byte_0};

  `SLCAN_ASSERT_NEXT(a_result_held, clk, rst, frame_valid && frame_stall,
    frame_valid && $stable(status) && $stable(frame_id) &&
    $stable(frame_length) && $stable(all_bytes))
  `SLCAN_ASSERT_SAME(a_error_zero, clk, rst, frame_valid && status,
    frame_id == 12'd0 && frame_length == 4'd0 && all_bytes == 64'd0)
  `SLCAN_ASSERT_SAME(a_length_limit, clk, rst, frame_valid && !status,
    frame_length <= MAX_LEN)
  `SLCAN_ASSERT_SAME(a_unused_bytes_zero, clk, rst, frame_valid && frame_length == 4'd0,
    all_bytes == 64'd0)

endmodule

bind slcan_ascii_frame_parser slcan_checker #(
  .MAX_DATA_BYTES (MAX_DATA_BYTES)
) u_checker (.*);
